/* hw/rtl/h_index_core_decomposition_unit_macros.svh */
// assertion macros shared by the h-index core decomposition rtl
`ifndef H_INDEX_CORE_DECOMPOSITION_UNIT_MACROS_SVH
`define H_INDEX_CORE_DECOMPOSITION_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define HICD_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define HICD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define HICD_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define HICD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/hicd_pkg.sv */
// shared types and constants for the h-index core decomposition unit
`timescale 1ns / 1ps
`default_nettype none
package hicd_pkg;
  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 16384;
  localparam int VTX_W        = 10;
  localparam int NCNT_W       = 11;
  localparam int EDGE_AW      = 14;
  localparam int EC_W         = 15;
  localparam int PASS_W       = 16;
  localparam int BKT_W        = 11;
  localparam int TOT_W        = 12;
  localparam int ENTRY_W      = 2 * VTX_W;

  localparam logic [NCNT_W-1:0] MAX_N      = NCNT_W'(MAX_VERTICES);
  localparam logic [VTX_W-1:0]  EST_CAP    = 10'd1023;
  localparam logic [BKT_W-1:0]  BUCKET_CAP = 11'd2047;
  localparam logic [PASS_W-1:0] PASS_CAP   = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic take;
    logic rd_out;
    logic vtx_start;
    logic vtx_end;
    logic deg_rd;
    logic deg_chk;
    logic init_wr;
    logic clr_wr;
    logic bk_start;
    logic bk_rd;
    logic bk_nb;
    logic bk_est;
    logic bk_inc;
    logic sc_start;
    logic sc_rd;
    logic sc_chk;
    logic upd_rd;
    logic upd_wr;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic out_full;
    logic r_end;
    logic p_end;
    logic row_hit;
    logic nb_ok;
    logic d_zero;
    logic k_at_cap;
    logic bk_end;
    logic k_zero;
    logic tot_hit;
    logic init_phase;
    logic changed;
  } stat_t;
endpackage
`default_nettype wire

/* hw/rtl/hicd_ctrl.sv */
// controller state machine sequencing load, run sweeps and reads
`timescale 1ns / 1ps
`default_nettype none
`include "h_index_core_decomposition_unit_macros.svh"
module hicd_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  hicd_pkg::mode_t  mode,
  input  hicd_pkg::stat_t  st,
  output hicd_pkg::cmd_t   cmd
);
  import hicd_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_READ    = 18'h00002,
    S_VTX     = 18'h00004,
    S_DEG_RD  = 18'h00008,
    S_DEG_CHK = 18'h00010,
    S_INIT_WR = 18'h00020,
    S_CLR     = 18'h00040,
    S_BKST    = 18'h00080,
    S_BK_RD   = 18'h00100,
    S_BK_NB   = 18'h00200,
    S_BK_EST  = 18'h00400,
    S_BK_INC  = 18'h00800,
    S_SCST    = 18'h01000,
    S_SC_RD   = 18'h02000,
    S_SC_CHK  = 18'h04000,
    S_UPD_RD  = 18'h08000,
    S_UPD_WR  = 18'h10000,
    S_FIN     = 18'h20000
  } state_t;

  state_t state, state_next, row_done;

  // where a row goes once its degree is known
  always_comb begin
    if (st.init_phase) begin
      row_done = S_INIT_WR;
    end else if (st.d_zero) begin
      row_done = S_UPD_RD;
    end else begin
      row_done = S_CLR;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = st.out_free;
        if (in_valid && st.out_free) begin
          cmd.take = 1'b1;
          case (mode)
            MODE_RUN:  state_next = S_VTX;
            MODE_READ: state_next = S_READ;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        cmd.rd_out = 1'b1;
        state_next = S_IDLE;
      end
      S_VTX: begin
        if (st.r_end) begin
          cmd.vtx_end = 1'b1;
          if (!st.init_phase && !st.changed) begin
            state_next = S_FIN;
          end
        end else begin
          cmd.vtx_start = 1'b1;
          state_next    = S_DEG_RD;
        end
      end
      S_DEG_RD: begin
        if (st.p_end) begin
          state_next = row_done;
        end else begin
          cmd.deg_rd = 1'b1;
          state_next = S_DEG_CHK;
        end
      end
      S_DEG_CHK: begin
        cmd.deg_chk = 1'b1;
        state_next  = st.row_hit ? S_DEG_RD : row_done;
      end
      S_INIT_WR: begin
        cmd.init_wr = 1'b1;
        state_next  = S_VTX;
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (st.k_at_cap) begin
          state_next = S_BKST;
        end
      end
      S_BKST: begin
        cmd.bk_start = 1'b1;
        state_next   = S_BK_RD;
      end
      S_BK_RD: begin
        if (st.bk_end) begin
          state_next = S_SCST;
        end else begin
          cmd.bk_rd  = 1'b1;
          state_next = S_BK_NB;
        end
      end
      S_BK_NB: begin
        cmd.bk_nb  = 1'b1;
        state_next = st.nb_ok ? S_BK_EST : S_BK_RD;
      end
      S_BK_EST: begin
        cmd.bk_est = 1'b1;
        state_next = S_BK_INC;
      end
      S_BK_INC: begin
        cmd.bk_inc = 1'b1;
        state_next = S_BK_RD;
      end
      S_SCST: begin
        cmd.sc_start = 1'b1;
        state_next   = S_SC_RD;
      end
      S_SC_RD: begin
        if (st.k_zero) begin
          state_next = S_UPD_RD;
        end else begin
          cmd.sc_rd  = 1'b1;
          state_next = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        cmd.sc_chk = 1'b1;
        state_next = st.tot_hit ? S_UPD_RD : S_SC_RD;
      end
      S_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_next = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_next = S_VTX;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a result lands only in an empty output slot
  `HICD_ASSERT_IMPL(a_read_slot_free, clk, rst, state == S_READ, !st.out_full)
  `HICD_ASSERT_IMPL(a_fin_slot_free, clk, rst, state == S_FIN, !st.out_full)
endmodule
`default_nettype wire

/* hw/rtl/hicd_dp.sv */
// datapath: entry store, estimates, buckets, counters and result register
`timescale 1ns / 1ps
`default_nettype none
`include "h_index_core_decomposition_unit_macros.svh"
module hicd_dp (
  input  wire                          clk,
  input  wire                          rst,
  input  hicd_pkg::cmd_t               cmd,
  output hicd_pkg::stat_t              st,
  input  hicd_pkg::mode_t              mode,
  input  wire [hicd_pkg::VTX_W-1:0]    vertex,
  input  wire [hicd_pkg::VTX_W-1:0]    neighbor,
  input  wire                          cfg_valid,
  input  wire [hicd_pkg::NCNT_W-1:0]   cfg_data,
  input  wire                          out_ready,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [hicd_pkg::VTX_W-1:0]   out_core,
  output logic [hicd_pkg::PASS_W-1:0]  out_pass
);
  import hicd_pkg::*;

  logic [ENTRY_W-1:0] store_mem [MAX_EDGES];
  logic [VTX_W-1:0]   est_mem   [MAX_VERTICES];
  logic [BKT_W-1:0]   bkt_mem   [MAX_VERTICES];

  logic [ENTRY_W-1:0] store_rdata;
  logic [VTX_W-1:0]   est_rdata;
  logic [BKT_W-1:0]   bkt_rdata;

  logic [NCNT_W-1:0]  vcount, n;
  logic [EC_W-1:0]    ec, p, row_ptr, row_end, d;
  logic [VTX_W-1:0]   cv, k, h, bx, cap, capd, x, nb;
  logic [NCNT_W-1:0]  r;
  logic [PASS_W-1:0]  passes, passes_inc;
  logic [TOT_W-1:0]   tot, tot_next;
  logic               changed, init_phase, rd_bad;

  logic               load_bad, load_full, self_loop, store_we;
  logic [1:0]         load_status;
  logic               est_we;
  logic [VTX_W-1:0]   est_raddr, est_wdata;
  logic               bkt_we;
  logic [VTX_W-1:0]   bkt_raddr, bkt_waddr;
  logic [BKT_W-1:0]   bkt_wdata, bkt_inc;

  assign n  = (vcount > MAX_N) ? MAX_N : vcount;
  assign nb = store_rdata[VTX_W-1:0];

  // load checks
  assign self_loop   = (vertex == neighbor);
  assign load_bad    = ({1'b0, vertex} >= n) || ({1'b0, neighbor} >= n) || (vertex < cv);
  assign load_full   = !self_loop && (ec >= EC_W'(MAX_EDGES));
  assign load_status = load_bad ? ST_RANGE : (load_full ? ST_FULL : ST_OK);
  assign store_we    = cmd.take && (mode == MODE_LOAD) && (load_status == ST_OK) && !self_loop;

  assign capd       = (d > EC_W'(EST_CAP)) ? EST_CAP : d[VTX_W-1:0];
  assign cap        = capd;
  assign x          = (est_rdata > cap) ? cap : est_rdata;
  assign bkt_inc    = (bkt_rdata == BUCKET_CAP) ? BUCKET_CAP : bkt_rdata + 11'd1;
  assign tot_next   = tot + {1'b0, bkt_rdata};
  assign passes_inc = (passes == PASS_CAP) ? PASS_CAP : passes + 16'd1;

  always_comb begin
    if (cmd.bk_nb) begin
      est_raddr = nb;
    end else if (cmd.upd_rd) begin
      est_raddr = r[VTX_W-1:0];
    end else begin
      est_raddr = vertex;
    end
  end
  assign est_we    = cmd.init_wr || (cmd.upd_wr && (h != est_rdata));
  assign est_wdata = cmd.init_wr ? capd : h;

  assign bkt_raddr = cmd.bk_est ? x : k;
  assign bkt_we    = cmd.clr_wr || cmd.bk_inc;
  assign bkt_waddr = cmd.clr_wr ? k : bx;
  assign bkt_wdata = cmd.clr_wr ? '0 : bkt_inc;

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[ec[EDGE_AW-1:0]] <= {vertex, neighbor};
    end
    store_rdata <= store_mem[p[EDGE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (est_we) begin
      est_mem[r[VTX_W-1:0]] <= est_wdata;
    end
    est_rdata <= est_mem[est_raddr];
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rdata <= bkt_mem[bkt_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount     <= MAX_N;
      ec         <= '0;
      cv         <= '0;
      passes     <= '0;
      changed    <= 1'b0;
      init_phase <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        vcount <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.take) begin
        case (mode)
          MODE_CLEAR: begin
            ec        <= '0;
            cv        <= '0;
            out_valid <= 1'b1;
          end
          MODE_LOAD: begin
            if (load_status == ST_OK) begin
              cv <= vertex;
            end
            if (store_we) begin
              ec <= ec + 15'd1;
            end
            out_valid <= 1'b1;
          end
          MODE_RUN: init_phase <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.rd_out || cmd.fin) begin
        out_valid <= 1'b1;
      end
      if (cmd.vtx_end) begin
        if (init_phase) begin
          init_phase <= 1'b0;
          changed    <= 1'b0;
          passes     <= '0;
        end else begin
          passes  <= passes_inc;
          changed <= 1'b0;
        end
      end
      if (cmd.upd_wr && (h != est_rdata)) begin
        changed <= 1'b1;
      end
    end
  end

  // run counters and result payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      r      <= '0;
      p      <= '0;
      rd_bad <= ({1'b0, vertex} >= n);
      out_core <= '0;
      out_pass <= passes;
      out_status <= (mode == MODE_LOAD) ? load_status : ST_OK;
    end
    if (cmd.rd_out) begin
      out_status <= rd_bad ? ST_RANGE : ST_OK;
      out_core   <= rd_bad ? '0 : est_rdata;
      out_pass   <= passes;
    end
    if (cmd.fin) begin
      out_status <= ST_OK;
      out_core   <= '0;
      out_pass   <= passes;
    end
    if (cmd.vtx_end && (init_phase || changed)) begin
      r <= '0;
      p <= '0;
    end
    if (cmd.vtx_start) begin
      row_ptr <= p;
      d       <= '0;
      k       <= '0;
      h       <= '0;
    end
    if (cmd.deg_chk && st.row_hit) begin
      if (st.nb_ok) begin
        d <= d + 15'd1;
      end
      p <= p + 15'd1;
    end
    if (cmd.init_wr || cmd.upd_wr) begin
      r <= r + 11'd1;
    end
    if (cmd.clr_wr && !st.k_at_cap) begin
      k <= k + 10'd1;
    end
    if (cmd.bk_start) begin
      row_end <= p;
      p       <= row_ptr;
    end
    if ((cmd.bk_nb && !st.nb_ok) || cmd.bk_inc) begin
      p <= p + 15'd1;
    end
    if (cmd.bk_est) begin
      bx <= x;
    end
    if (cmd.sc_start) begin
      k   <= cap;
      tot <= '0;
    end
    if (cmd.sc_chk) begin
      if (st.tot_hit) begin
        h <= k;
      end else begin
        k   <= k - 10'd1;
        tot <= tot_next;
      end
    end
  end

  assign st.out_free   = !out_valid || out_ready;
  assign st.out_full   = out_valid;
  assign st.r_end      = (r == n);
  assign st.p_end      = (p >= ec);
  assign st.row_hit    = (store_rdata[ENTRY_W-1:VTX_W] == r[VTX_W-1:0]);
  assign st.nb_ok      = ({1'b0, nb} < n);
  assign st.d_zero     = (d == '0);
  assign st.k_at_cap   = (k == cap);
  assign st.bk_end     = (p == row_end);
  assign st.k_zero     = (k == '0);
  assign st.tot_hit    = (tot_next >= {2'b00, k});
  assign st.init_phase = init_phase;
  assign st.changed    = changed;

  `HICD_ASSERT_ALWAYS(a_ec_bound, clk, rst, ec <= EC_W'(MAX_EDGES))
  // running total stays at or below the candidate while scanning down
  `HICD_ASSERT_IMPL(a_scan_tot, clk, rst, cmd.sc_chk, tot <= {2'b00, k})
endmodule
`default_nettype wire

/* hw/rtl/h_index_core_decomposition_unit.sv */
// top level of the h-index core decomposition unit
// Usage: commands enter on the s_axis channel, one result per command leaves on
// m_axis. s_axis_tuser carries the mode (clear, load entry, run, read core),
// s_axis_tdata the vertex and neighbor. m_axis_tuser carries the status,
// m_axis_tdata the core value and the pass count of the last run.
// The cfg channel writes vertex_count (always ready); write it only while idle.
// Clear and load are taken in the idle state, so adjacency entries stream in
// at one per cycle while results are drained. A read registers the estimate
// ram output first. A run starts with a degree pass that sets each estimate
// to the vertex's live degree, capped at 1023; each sweep then buckets the
// neighbor estimates, scans down for the h-index and writes it back (zero for
// a vertex with no live neighbor). The entry store and the bucket ram each
// give one read per cycle. Sweeps repeat until one changes no estimate, and
// the pass count of the result gives the sweeps.
// Reset restores vertex_count to 1024 and empties the graph; estimates persist
// across clears. When m_axis_tready is low the result holds in the output
// register and s_axis_tready stays low until that result is taken.
`timescale 1ns / 1ps
`default_nettype none
module h_index_core_decomposition_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // vertex[9:0], neighbor[19:10], zero pad
  input  wire  [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // core_value[9:0], pass_count[25:10], zero pad
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [10:0] cfg_data        // vertex_count
);
  import hicd_pkg::*;

  cmd_t                cmd;
  stat_t               st;
  mode_t               mode;
  logic [VTX_W-1:0]    out_core;
  logic [PASS_W-1:0]   out_pass;

  assign mode      = mode_t'(s_axis_tuser);
  assign cfg_ready = 1'b1;

  hicd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .mode     (mode),
    .st       (st),
    .cmd      (cmd)
  );

  hicd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .mode       (mode),
    .vertex     (s_axis_tdata[9:0]),
    .neighbor   (s_axis_tdata[19:10]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_core   (out_core),
    .out_pass   (out_pass)
  );

  assign m_axis_tdata = {6'b000000, out_pass, out_core};
endmodule
`default_nettype wire
